/* src/ragt_pkg.sv */
// Shared types for the reference-counted access grant table.
// Holds the mode codes, controller states and controller/datapath link structs.
// No dependencies.
package ragt_pkg;

    typedef enum logic [1:0] {
        MODE_COUNTED = 2'd0,
        MODE_ONCE    = 2'd1,
        MODE_REVOKE  = 2'd2,
        MODE_QUERY   = 2'd3
    } ragt_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOOKUP = 2'd1,
        ST_COMMIT = 2'd2
    } ragt_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic commit;
    } ragt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } ragt_sts_t;

endpackage

/* src/ragt_ctrl.sv */
// Controller state machine of the access grant table.
// Sequences accept, lookup and commit; depends on ragt_pkg.
module ragt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ragt_pkg::ragt_sts_t sts,
    output ragt_pkg::ragt_cmd_t cmd
);
    import ragt_pkg::*;

    ragt_state_t state_reg;
    ragt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.lookup = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_COMMIT:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // An item must never be taken while another is still in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.lookup)
        else $error("ragt_ctrl: accepted item did not move to lookup");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> (state_reg == ST_COMMIT))
        else $error("ragt_ctrl: lookup not followed by commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit || cmd.lookup) |-> in_stall)
        else $error("ragt_ctrl: input open while an item is in flight");

endmodule

/* src/ragt_datapath.sv */
// Datapath of the access grant table: entry storage, parallel key match,
// free-entry pick, count update and output register. Depends on ragt_pkg.
module ragt_datapath #(
    parameter int ENTRIES     = 16,
    parameter int TAG_BITS    = 32,
    parameter int OBJECT_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ragt_pkg::ragt_cmd_t cmd,
    output ragt_pkg::ragt_sts_t sts,
    input  logic [1:0]          mode,
    input  logic [15:0]         object_id,
    input  logic [31:0]         file_tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                status,
    output logic                allowed,
    output logic [15:0]         use_count
);
    import ragt_pkg::*;

    // Only the low key bits that fit the ports take part in the match.
    localparam int OBJ_W = (OBJECT_BITS < 16) ? OBJECT_BITS : 16;
    localparam int TAG_W = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int OUT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Latched item.
    ragt_mode_t         mode_reg;
    logic [OBJ_W-1:0]   obj_reg;
    logic [TAG_W-1:0]   tag_reg;

    // Entry storage.
    logic [ENTRIES-1:0] valid_reg;
    logic [OBJ_W-1:0]   slot_obj_reg [ENTRIES];
    logic [TAG_W-1:0]   slot_tag_reg [ENTRIES];
    logic [COUNT_BITS-1:0] slot_cnt_reg [ENTRIES];

    // Lookup results.
    logic [ENTRIES-1:0] hit_next;
    logic [ENTRIES-1:0] hit_reg;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] first_free_next;
    logic [ENTRIES-1:0] first_free_reg;

    // Commit decisions.
    logic [COUNT_BITS-1:0] hit_cnt;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic                  any_hit;
    logic                  any_free;
    logic                  wr_en;
    logic                  wr_insert;
    logic                  wr_clear;
    logic [ENTRIES-1:0]    wr_sel;
    logic [COUNT_BITS-1:0] wr_cnt;
    logic                  res_status;
    logic                  res_allowed;
    logic [COUNT_BITS-1:0] res_cnt;

    // Output register.
    logic                  out_valid_reg;
    logic                  status_reg;
    logic                  allowed_reg;
    logic [COUNT_BITS-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= ragt_mode_t'(mode);
            obj_reg  <= object_id[OBJ_W-1:0];
            tag_reg  <= file_tag[TAG_W-1:0];
        end
    end

    // Every entry compares against the key at once.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_next[i] = valid_reg[i] && (slot_obj_reg[i] == obj_reg)
                          && (slot_tag_reg[i] == tag_reg);
        end
    end

    // Lowest free entry: isolate the lowest set bit of the free vector.
    assign free_vec        = ~valid_reg;
    assign first_free_next = free_vec & (~free_vec + ENTRIES'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg        <= hit_next;
            first_free_reg <= first_free_next;
        end
    end

    // Entries are unique, so the hit vector selects at most one count.
    always_comb
    begin
        hit_cnt = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_cnt = hit_cnt | ({COUNT_BITS{hit_reg[i]}} & slot_cnt_reg[i]);
        end
    end

    assign any_hit  = |hit_reg;
    assign any_free = |first_free_reg;
    assign cnt_inc  = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + CNT_ONE;
    assign cnt_dec  = hit_cnt - CNT_ONE;

    always_comb
    begin
        wr_en       = 1'b0;
        wr_insert   = 1'b0;
        wr_clear    = 1'b0;
        wr_sel      = hit_reg;
        wr_cnt      = hit_cnt;
        res_status  = 1'b0;
        res_allowed = 1'b0;
        res_cnt     = '0;
        case (mode_reg)
            MODE_COUNTED, MODE_ONCE:
            begin
                if (any_hit)
                begin
                    wr_en       = 1'b1;
                    wr_cnt      = (mode_reg == MODE_COUNTED) ? cnt_inc : hit_cnt;
                    res_allowed = 1'b1;
                    res_cnt     = wr_cnt;
                end
                else if (any_free)
                begin
                    wr_en       = 1'b1;
                    wr_insert   = 1'b1;
                    wr_sel      = first_free_reg;
                    wr_cnt      = CNT_ONE;
                    res_allowed = 1'b1;
                    res_cnt     = CNT_ONE;
                end
                else
                begin
                    res_status = 1'b1;
                end
            end
            MODE_REVOKE:
            begin
                if (any_hit)
                begin
                    wr_en = 1'b1;
                    if (hit_cnt <= CNT_ONE)
                    begin
                        wr_clear = 1'b1;
                        wr_cnt   = '0;
                    end
                    else
                    begin
                        wr_cnt      = cnt_dec;
                        res_allowed = 1'b1;
                        res_cnt     = cnt_dec;
                    end
                end
            end
            MODE_QUERY:
            begin
                if (any_hit)
                begin
                    res_allowed = 1'b1;
                    res_cnt     = hit_cnt;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (cmd.commit && wr_en && wr_sel[i])
                begin
                    valid_reg[i] <= !wr_clear;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.commit && wr_en && wr_sel[i])
            begin
                slot_cnt_reg[i] <= wr_cnt;
                if (wr_insert)
                begin
                    slot_obj_reg[i] <= obj_reg;
                    slot_tag_reg[i] <= tag_reg;
                end
            end
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= res_status;
            allowed_reg <= res_allowed;
            count_reg   <= res_cnt;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign allowed   = allowed_reg;
    assign use_count = 16'(count_reg[OUT_W-1:0]);

    // A key can live in at most one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.lookup) |-> $onehot0(hit_reg))
        else $error("ragt_datapath: key matched more than one entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.lookup) |-> $onehot0(first_free_reg))
        else $error("ragt_datapath: free pick is not a single entry");

    // A failed insert means the table stays full while its result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg) |-> (&valid_reg))
        else $error("ragt_datapath: table full reported with a free entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("ragt_datapath: committed item left no result");

endmodule

/* src/refcounted_access_grant_table.sv */
// Reference-counted access grant table, top level. A result is valid once its
// item has passed the accept, lookup and commit steps of the controller, or
// later while the output is stalled. A new item is accepted only after the
// previous one has committed. Reset (rst_n, asynchronous, active low) clears all
// grant valid bits and the output valid flag at once; no clearing pass is needed.
// Depends on ragt_pkg, ragt_ctrl and ragt_datapath.
module refcounted_access_grant_table #(
    parameter int ENTRIES     = 16,
    parameter int TAG_BITS    = 32,
    parameter int OBJECT_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [15:0] object_id,
    input  logic [31:0] file_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic        allowed,
    output logic [15:0] use_count
);
    import ragt_pkg::*;

    // The controller walks each item through three steps. In the accept step
    // the item is latched. In the lookup step every entry compares its
    // (object, tag) key with the item at once, and the lowest free entry is
    // isolated; both vectors are registered. In the commit step the matched
    // count is selected, the single affected entry is updated, and the result
    // is written to the output register. The commit waits only when the
    // output register still holds an untaken result, so a new item can be
    // accepted while an earlier result sits waiting downstream.

    ragt_cmd_t cmd;
    ragt_sts_t sts;

    ragt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ragt_datapath #(
        .ENTRIES     (ENTRIES),
        .TAG_BITS    (TAG_BITS),
        .OBJECT_BITS (OBJECT_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .object_id (object_id),
        .file_tag  (file_tag),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .allowed   (allowed),
        .use_count (use_count)
    );

endmodule
